>>> hw/rtl/ach_pkg.sv
// shared types and constants of the adaptive cluster halftoner
// no dependencies; imported by every module of the block but ach_ram
package ach_pkg;

  localparam int MAX_CLUSTER_DEF = 32;
  localparam int STORE_EXTRA     = 8;
  localparam int TAPS            = 7;
  localparam int FULL_BLACK      = 255;
  localparam int CMDQ_DEPTH      = 4;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_CLUSTER_LIMIT    = 2'd0;
  localparam logic [1:0] REG_EDGE_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_ADAPTIVE_ENABLE  = 2'd2;
  localparam logic [1:0] REG_SELECTIVE_ENABLE = 2'd3;

  localparam logic [5:0]  RST_CLUSTER_LIMIT    = 6'd8;
  localparam logic [12:0] RST_EDGE_THRESHOLD   = 13'd40;
  localparam logic        RST_ADAPTIVE_ENABLE  = 1'b1;
  localparam logic        RST_SELECTIVE_ENABLE = 1'b1;

  // laplacian-of-gaussian taps, oldest pixel first
  localparam logic signed [13:0] LOG_TAPS [TAPS] = '{
    -14'sd1, -14'sd5, 14'sd0, 14'sd13, 14'sd0, -14'sd5, -14'sd1
  };

  typedef struct packed {
    logic [5:0]  cluster_limit;
    logic [12:0] edge_threshold;
    logic        adaptive_enable;
    logic        selective_enable;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_FLUSH,
    OP_FLUSH_CLR,
    OP_END
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] gray;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_APP_NEW,
    F_TAIL,
    F_FILTER,
    F_APP_CTR,
    F_REPL,
    F_FLUSH_END,
    F_END
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SEARCH,
    B_EMIT
  } back_state_t;

endpackage

>>> hw/rtl/ach_ram.sv
// generic ram: one write port, two read ports with registered read data
// no dependencies
module ach_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  output logic [WIDTH-1:0]         rdata0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata0 <= mem_r[raddr0];
    rdata1 <= mem_r[raddr1];
  end

endmodule

>>> hw/rtl/ach_cmdq.sv
// short command queue between the classifying front and the flush engine
// depends on ach_pkg
module ach_cmdq import ach_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int PW = $clog2(CMDQ_DEPTH);

  cmd_t        slot_r [CMDQ_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(CMDQ_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot_r[wp_r] <= push_cmd;
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop && !empty) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

>>> hw/rtl/ach_front.sv
// front: takes pixels, runs the log filter and the edge test, issues
// append / flush / flush_clr / end commands; depends on ach_pkg
module ach_front import ach_pkg::*; #(
  parameter int MAX_CLUSTER = MAX_CLUSTER_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_gray,
  input  logic       in_final_pixel,
  input  cfg_t       cfg,
  output logic       push,
  output cmd_t       push_cmd,
  input  logic       q_full
);

  localparam int DEPTH = MAX_CLUSTER + STORE_EXTRA;
  localparam int CW    = $clog2(DEPTH + 1);

  front_state_t       state_r, state_nxt;
  logic [7:0]         win_r [TAPS];
  logic [7:0]         win_nxt [TAPS];
  logic [2:0]         fill_r, fill_nxt;
  logic signed [12:0] prev_r, prev_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [7:0]         g_r, g_nxt;
  logic               fin_r, fin_nxt;
  logic               first_r, first_nxt;
  logic [1:0]         rep_r, rep_nxt;
  logic [2:0]         idx_r, idx_nxt;

  logic signed [13:0] conv_w;
  logic signed [12:0] conv;
  logic signed [12:0] prev_eff;
  logic signed [13:0] diff;
  logic [13:0]        absdiff;
  logic               zero_cross, change, need_flush;
  logic [7:0]         lim;
  logic [2:0]         tidx;
  logic [CW-1:0]      cnt_inc;

  always_comb begin
    conv_w = '0;
    for (int k = 0; k < TAPS; k++) begin
      conv_w = conv_w + LOG_TAPS[k] * $signed({6'b0, win_r[k]});
    end
  end

  assign conv     = conv_w[12:0];
  assign prev_eff = first_r ? conv : prev_r;
  assign diff     = {conv[12], conv} - {prev_eff[12], prev_eff};
  assign absdiff  = diff[13] ? 14'(-diff) : 14'(diff);
  assign zero_cross = (conv >= 0 && prev_eff <= 0) || (conv <= 0 && prev_eff >= 0);
  assign change   = cfg.adaptive_enable && zero_cross && (absdiff > {1'b0, cfg.edge_threshold});

  always_comb begin
    lim = {2'b0, cfg.cluster_limit};
    if (lim == 8'd0) begin
      lim = 8'd1;
    end
    if (lim > 8'(MAX_CLUSTER)) begin
      lim = 8'(MAX_CLUSTER);
    end
  end

  assign need_flush = change || (8'(cnt_r) >= lim);
  assign tidx       = 3'(3'd7 - fill_r + idx_r);
  assign cnt_inc    = (cnt_r < CW'(DEPTH)) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fill_r  <= '0;
      prev_r  <= '0;
      cnt_r   <= '0;
      for (int k = 0; k < TAPS; k++) begin
        win_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      prev_r  <= prev_nxt;
      cnt_r   <= cnt_nxt;
      win_r   <= win_nxt;
    end
    g_r     <= g_nxt;
    fin_r   <= fin_nxt;
    first_r <= first_nxt;
    rep_r   <= rep_nxt;
    idx_r   <= idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    win_nxt       = win_r;
    fill_nxt      = fill_r;
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    g_nxt         = g_r;
    fin_nxt       = fin_r;
    first_nxt     = first_r;
    rep_nxt       = rep_r;
    idx_nxt       = idx_r;
    in_ready      = 1'b0;
    push          = 1'b0;
    push_cmd.op   = OP_APPEND;
    push_cmd.gray = g_r;

    unique case (state_r)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          for (int k = 0; k < TAPS - 1; k++) begin
            win_nxt[k] = win_r[k+1];
          end
          win_nxt[TAPS-1] = in_gray;
          g_nxt   = in_gray;
          fin_nxt = in_final_pixel;
          idx_nxt = 3'd3;
          if (fill_r < 3'd6) begin
            fill_nxt = fill_r + 1'b1;
            if (fill_r < 3'd3) begin
              state_nxt = F_APP_NEW;
            end else if (in_final_pixel) begin
              state_nxt = F_TAIL;
            end else begin
              state_nxt = F_END;
            end
          end else begin
            fill_nxt  = 3'd7;
            first_nxt = (fill_r == 3'd6);
            rep_nxt   = '0;
            state_nxt = F_FILTER;
          end
        end
      end
      F_APP_NEW: begin
        if (!q_full) begin
          push      = 1'b1;
          cnt_nxt   = cnt_inc;
          state_nxt = fin_r ? F_TAIL : F_END;
        end
      end
      F_TAIL: begin
        // short image: pixels still in the window join the cluster
        if (idx_r < fill_r) begin
          push_cmd.gray = win_r[tidx];
          if (!q_full) begin
            push    = 1'b1;
            cnt_nxt = cnt_inc;
            idx_nxt = idx_r + 1'b1;
          end
        end else begin
          state_nxt = F_FLUSH_END;
        end
      end
      F_FILTER: begin
        push_cmd.op = OP_FLUSH;
        if (!need_flush || !q_full) begin
          push      = need_flush;
          if (need_flush) begin
            cnt_nxt = '0;
          end
          prev_nxt  = conv;
          first_nxt = 1'b0;
          state_nxt = F_APP_CTR;
        end
      end
      F_APP_CTR: begin
        push_cmd.gray = win_r[3];
        if (!q_full) begin
          push    = 1'b1;
          cnt_nxt = cnt_inc;
          if (fin_r && rep_r != 2'd3) begin
            state_nxt = F_REPL;
          end else if (fin_r) begin
            state_nxt = F_FLUSH_END;
          end else begin
            state_nxt = F_END;
          end
        end
      end
      F_REPL: begin
        // end of image: last pixel repeated to finish the filter
        for (int k = 0; k < TAPS - 1; k++) begin
          win_nxt[k] = win_r[k+1];
        end
        win_nxt[TAPS-1] = g_r;
        rep_nxt   = rep_r + 1'b1;
        state_nxt = F_FILTER;
      end
      F_FLUSH_END: begin
        push_cmd.op = OP_FLUSH_CLR;
        if (!q_full) begin
          push      = 1'b1;
          cnt_nxt   = '0;
          state_nxt = F_END;
        end
      end
      F_END: begin
        push_cmd.op = OP_END;
        if (!q_full) begin
          push      = 1'b1;
          state_nxt = F_IDLE;
          if (fin_r) begin
            fill_nxt = '0;
            prev_nxt = '0;
            cnt_nxt  = '0;
            for (int k = 0; k < TAPS; k++) begin
              win_nxt[k] = '0;
            end
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

endmodule

>>> hw/rtl/ach_back.sv
// back: cluster store, gray accumulator, window search and dot emission
// depends on ach_pkg and ach_ram
module ach_back import ach_pkg::*; #(
  parameter int MAX_CLUSTER = MAX_CLUSTER_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_empty,
  input  cmd_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output logic out_dot,
  output logic out_run_end
);

  localparam int DEPTH = MAX_CLUSTER + STORE_EXTRA;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int ACC_W = $clog2(FULL_BLACK * (DEPTH + 1) + 1);
  localparam int SW    = $clog2(FULL_BLACK * DEPTH + 1);

  back_state_t  state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CW-1:0]    len_r, len_nxt;
  logic [CW-1:0]    start_r, start_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    ip_r, ip_nxt;
  logic             rdv_r, rdv_nxt;
  logic [SW-1:0]    sum_r, sum_nxt;
  logic [SW-1:0]    best_r, best_nxt;
  logic             clr_r, clr_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             pend_dot_r, pend_dot_nxt;
  logic             ov_r, ov_nxt;
  logic             odot_r, odot_nxt;
  logic             oend_r, oend_nxt;

  logic             we;
  logic [7:0]       rdata0, rdata1;
  logic [ACC_W:0]   q_w;
  logic [CW-1:0]    quot;
  logic [SW-1:0]    new_sum;
  logic             out_free, emit_ok, dot, emit_last;

  ach_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk    (clk),
    .we     (we),
    .waddr  (cnt_r[AW-1:0]),
    .wdata  (head.gray),
    .raddr0 (i_r[AW-1:0]),
    .rdata0 (rdata0),
    .raddr1 (AW'(i_r - len_r)),
    .rdata1 (rdata1)
  );

  // acc / 255 by reciprocal: (x + (x >> 8) + 1) >> 8
  assign q_w  = ({1'b0, acc_r} + (ACC_W+1)'(acc_r >> 8) + 1'b1) >> 8;
  assign quot = CW'(q_w);

  assign new_sum   = sum_r + SW'(rdata0) - ((ip_r >= len_r) ? SW'(rdata1) : '0);
  assign out_free  = !ov_r || out_ready;
  assign emit_ok   = !pend_v_r || out_free;
  assign dot       = (acc_r >= ACC_W'(FULL_BLACK)) && (i_r >= start_r);
  assign emit_last = (i_r == CW'(cnt_r - 1'b1));

  assign out_valid   = ov_r;
  assign out_dot     = odot_r;
  assign out_run_end = oend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      cnt_r    <= '0;
      acc_r    <= '0;
      rdv_r    <= 1'b0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      rdv_r    <= rdv_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
    len_r      <= len_nxt;
    start_r    <= start_nxt;
    i_r        <= i_nxt;
    ip_r       <= ip_nxt;
    sum_r      <= sum_nxt;
    best_r     <= best_nxt;
    clr_r      <= clr_nxt;
    pend_dot_r <= pend_dot_nxt;
    odot_r     <= odot_nxt;
    oend_r     <= oend_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    acc_nxt      = acc_r;
    len_nxt      = len_r;
    start_nxt    = start_r;
    i_nxt        = i_r;
    ip_nxt       = i_r;
    rdv_nxt      = 1'b0;
    sum_nxt      = sum_r;
    best_nxt     = best_r;
    clr_nxt      = clr_r;
    pend_v_nxt   = pend_v_r;
    pend_dot_nxt = pend_dot_r;
    ov_nxt       = ov_r && !out_ready;
    odot_nxt     = odot_r;
    oend_nxt     = oend_r;
    pop          = 1'b0;
    we           = 1'b0;

    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          unique case (head.op) inside
            OP_APPEND: begin
              pop = 1'b1;
              if (cnt_r < CW'(DEPTH)) begin
                we      = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
                acc_nxt = acc_r + ACC_W'(head.gray);
              end
            end
            OP_FLUSH, OP_FLUSH_CLR: begin
              pop     = 1'b1;
              clr_nxt = (head.op == OP_FLUSH_CLR);
              if (cnt_r == '0) begin
                if (head.op == OP_FLUSH_CLR) begin
                  acc_nxt = '0;
                end
              end else begin
                len_nxt   = (quot > cnt_r) ? cnt_r : quot;
                start_nxt = '0;
                i_nxt     = '0;
                sum_nxt   = '0;
                best_nxt  = '0;
                state_nxt = cfg.selective_enable ? B_SEARCH : B_EMIT;
              end
            end
            OP_END: begin
              // the held result is the last one of this transfer
              if (!pend_v_r) begin
                pop = 1'b1;
              end else if (out_free) begin
                pop        = 1'b1;
                ov_nxt     = 1'b1;
                odot_nxt   = pend_dot_r;
                oend_nxt   = 1'b1;
                pend_v_nxt = 1'b0;
              end
            end
            default: pop = 1'b0;
          endcase
        end
      end
      B_SEARCH: begin
        // sliding window sum, read data arrives in the cycle after its index
        if (i_r < cnt_r) begin
          rdv_nxt = 1'b1;
          i_nxt   = i_r + 1'b1;
        end
        if (rdv_r) begin
          sum_nxt = new_sum;
          if (ip_r < len_r) begin
            if (ip_r == CW'(len_r - 1'b1)) begin
              best_nxt = new_sum;
            end
          end else if (new_sum > best_r) begin
            best_nxt  = new_sum;
            start_nxt = CW'(ip_r - len_r + 1'b1);
          end
        end
        if (i_r == cnt_r && !rdv_r) begin
          i_nxt     = '0;
          state_nxt = B_EMIT;
        end
      end
      B_EMIT: begin
        if (emit_ok) begin
          if (dot) begin
            acc_nxt = acc_r - ACC_W'(FULL_BLACK);
          end
          if (pend_v_r) begin
            ov_nxt   = 1'b1;
            odot_nxt = pend_dot_r;
            oend_nxt = 1'b0;
          end
          pend_v_nxt   = 1'b1;
          pend_dot_nxt = dot;
          i_nxt        = i_r + 1'b1;
          if (emit_last) begin
            cnt_nxt   = '0;
            state_nxt = B_IDLE;
            if (clr_r) begin
              acc_nxt = '0;
            end
          end
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("cluster count beyond store depth");

  a_start_in_cluster: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_EMIT |-> start_r < cnt_r)
    else $error("dot window starts outside the cluster");

  a_residual_small: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_EMIT && emit_ok && emit_last) |=> acc_r < ACC_W'(FULL_BLACK))
    else $error("residual gray after flush not below one dot");
`endif

endmodule

>>> hw/rtl/adaptive_cluster_halftoner_top.sv
// with selective_enable set, the back walks the cluster store in a window search before
// the first dot of a flush; the front runs the filter per pixel once its window is full,
// the back takes one append and one end command per pixel plus two store walks per
// flushed pixel (one with selective_enable clear), so flushes stall the front
// reset: rst_n synchronous, clears stream state and loads register defaults
module adaptive_cluster_halftoner_top import ach_pkg::*; #(
  parameter int MAX_CLUSTER = MAX_CLUSTER_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_gray,
  input  logic        in_final_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_dot,
  output logic        out_run_end,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_empty;
  cmd_t q_in, q_head;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cluster_limit    <= RST_CLUSTER_LIMIT;
      cfg_r.edge_threshold   <= RST_EDGE_THRESHOLD;
      cfg_r.adaptive_enable  <= RST_ADAPTIVE_ENABLE;
      cfg_r.selective_enable <= RST_SELECTIVE_ENABLE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_CLUSTER_LIMIT:    cfg_r.cluster_limit    <= pwdata[5:0];
        REG_EDGE_THRESHOLD:   cfg_r.edge_threshold   <= pwdata[12:0];
        REG_ADAPTIVE_ENABLE:  cfg_r.adaptive_enable  <= pwdata[0];
        REG_SELECTIVE_ENABLE: cfg_r.selective_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CLUSTER_LIMIT:    prdata = {26'b0, cfg_r.cluster_limit};
      REG_EDGE_THRESHOLD:   prdata = {19'b0, cfg_r.edge_threshold};
      REG_ADAPTIVE_ENABLE:  prdata = {31'b0, cfg_r.adaptive_enable};
      REG_SELECTIVE_ENABLE: prdata = {31'b0, cfg_r.selective_enable};
      default:              prdata = '0;
    endcase
  end

  ach_front #(
    .MAX_CLUSTER (MAX_CLUSTER)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_gray        (in_gray),
    .in_final_pixel (in_final_pixel),
    .cfg            (cfg_r),
    .push           (q_push),
    .push_cmd       (q_in),
    .q_full         (q_full)
  );

  ach_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  ach_back #(
    .MAX_CLUSTER (MAX_CLUSTER)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_dot     (out_dot),
    .out_run_end (out_run_end)
  );

endmodule
